// ===== rtl/tmisd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmisd_pkg: shared types and constants for the torus distance block
// Item formats, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package tmisd_pkg;

  // Largest side length; larger register values are clamped to it
  localparam int MAX_SIDE  = 256;
  localparam int SIDE_W    = 9;
  localparam int SITE_W    = 16;
  localparam int COORD_W   = 8;
  localparam int DIST_W    = 17;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'd1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd16;

  typedef struct packed {
    logic [SITE_W-1:0] site_a;
    logic [SITE_W-1:0] site_b;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] sq_distance;
    logic              index_error;
  } out_item_t;

  // Clamp a side length register value to the supported range
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] lim;
    lim = SIDE_W'(MAX_SIDE);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ===== rtl/torus_min_image_sq_distance.sv =====
// ----------------------------------------------------------------------------
// torus_min_image_sq_distance: periodic minimum-image squared distance
// Splits two lattice site indices into column and row with a pipelined
// restoring divider, then takes the shortest wrap per axis and sums squares.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_stall is low; one quotient bit per
// divider stage sets the pipeline depth (8 divider stages between capture and
// the distance stages).
// Reset: clears all stage valid bits and sets both side lengths to 16.
// Backpressure: each stage holds while the stage after it is full and stalled.
module torus_min_image_sq_distance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tmisd_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tmisd_pkg::out_item_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tmisd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmisd_pkg::SIDE_W-1:0]        cfg_data
);
  import tmisd_pkg::*;

  localparam int DIV_LAST = COORD_W;
  localparam int ST_DIFF  = DIV_LAST + 1;
  localparam int ST_MIN   = DIV_LAST + 2;
  localparam int ST_SQ    = DIV_LAST + 3;
  localparam int ST_OUT   = DIV_LAST + 4;
  localparam int NS       = ST_OUT + 1;
  localparam int REM_W    = SITE_W + 1;
  localparam int SQ_W     = 2 * COORD_W;

  // Configuration: clamped sides and the site count
  logic [SIDE_W-1:0] w_eff_r, l_eff_r, w_eff_nxt, l_eff_nxt;
  logic [DIST_W-1:0] n_r, n_nxt;

  // Stage control
  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  // Divider payload
  logic [SITE_W-1:0]  rem_a_r [0:DIV_LAST];
  logic [SITE_W-1:0]  rem_b_r [0:DIV_LAST];
  logic [COORD_W-1:0] q_a_r   [0:DIV_LAST];
  logic [COORD_W-1:0] q_b_r   [0:DIV_LAST];
  logic [SITE_W-1:0]  rem_a_nxt [1:DIV_LAST];
  logic [SITE_W-1:0]  rem_b_nxt [1:DIV_LAST];
  logic [COORD_W-1:0] q_a_nxt   [1:DIV_LAST];
  logic [COORD_W-1:0] q_b_nxt   [1:DIV_LAST];
  logic               err_r [0:ST_SQ];

  // Distance payload
  logic [COORD_W-1:0] dx_r, dy_r, mx_r, my_r;
  logic               xdiff_r, ydiff_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;
  out_item_t          out_r;

  logic [COORD_W-1:0] dx_nxt, dy_nxt, mx_nxt, my_nxt;
  logic               xdiff_nxt, ydiff_nxt;
  logic [SIDE_W-1:0]  altx, alty;
  logic               in_err;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    w_eff_nxt = w_eff_r;
    l_eff_nxt = l_eff_r;
    case (cfg_index)
      REG_WIDTH:  w_eff_nxt = clamp_side(cfg_data);
      REG_LENGTH: l_eff_nxt = clamp_side(cfg_data);
      default: ;
    endcase
    n_nxt = DIST_W'(w_eff_nxt * l_eff_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= SIDE_RESET;
      l_eff_r <= SIDE_RESET;
      n_r     <= DIST_W'(SIDE_RESET * SIDE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      w_eff_r <= w_eff_nxt;
      l_eff_r <= l_eff_nxt;
      n_r     <= n_nxt;
    end
  end

  // Ready chain: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[NS] = !out_stall;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[ST_OUT];
  assign out_data  = out_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // Range check at capture
  assign in_err = ({1'b0, in_data.site_a} >= n_r) || ({1'b0, in_data.site_b} >= n_r);

  // Divider steps: one quotient bit per stage, most significant first
  always_comb begin
    logic [REM_W-1:0] ws;
    logic             ta, tb;
    for (int s = 1; s <= DIV_LAST; s++) begin
      ws = REM_W'(w_eff_r) << (DIV_LAST - s);
      ta = {1'b0, rem_a_r[s-1]} >= ws;
      tb = {1'b0, rem_b_r[s-1]} >= ws;
      rem_a_nxt[s] = ta ? SITE_W'({1'b0, rem_a_r[s-1]} - ws) : rem_a_r[s-1];
      rem_b_nxt[s] = tb ? SITE_W'({1'b0, rem_b_r[s-1]} - ws) : rem_b_r[s-1];
      q_a_nxt[s]   = {q_a_r[s-1][COORD_W-2:0], ta};
      q_b_nxt[s]   = {q_b_r[s-1][COORD_W-2:0], tb};
    end
  end

  // Per-axis offsets and half comparison
  always_comb begin
    logic [COORD_W-1:0] ax, bx, ay, by;
    logic [SIDE_W-1:0]  hw, hl;
    ax = rem_a_r[DIV_LAST][COORD_W-1:0];
    bx = rem_b_r[DIV_LAST][COORD_W-1:0];
    ay = q_a_r[DIV_LAST];
    by = q_b_r[DIV_LAST];
    hw = w_eff_r >> 1;
    hl = l_eff_r >> 1;
    dx_nxt    = (ax > bx) ? ax - bx : bx - ax;
    dy_nxt    = (ay > by) ? ay - by : by - ay;
    xdiff_nxt = ({1'b0, ax} >= hw) ^ ({1'b0, bx} >= hw);
    ydiff_nxt = ({1'b0, ay} >= hl) ^ ({1'b0, by} >= hl);
  end

  // Shorter of direct and wrapped offset, wrap only across halves
  always_comb begin
    altx   = w_eff_r - SIDE_W'(dx_r);
    alty   = l_eff_r - SIDE_W'(dy_r);
    mx_nxt = (xdiff_r && (altx < SIDE_W'(dx_r))) ? altx[COORD_W-1:0] : dx_r;
    my_nxt = (ydiff_r && (alty < SIDE_W'(dy_r))) ? alty[COORD_W-1:0] : dy_r;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem_a_r[0] <= in_data.site_a;
      rem_b_r[0] <= in_data.site_b;
      q_a_r[0]   <= '0;
      q_b_r[0]   <= '0;
      err_r[0]   <= in_err;
    end
    for (int s = 1; s <= DIV_LAST; s++) begin
      if (rdy[s]) begin
        rem_a_r[s] <= rem_a_nxt[s];
        rem_b_r[s] <= rem_b_nxt[s];
        q_a_r[s]   <= q_a_nxt[s];
        q_b_r[s]   <= q_b_nxt[s];
      end
    end
    for (int s = 1; s <= ST_SQ; s++) begin
      if (rdy[s]) begin
        err_r[s] <= err_r[s-1];
      end
    end
    if (rdy[ST_DIFF]) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      xdiff_r <= xdiff_nxt;
      ydiff_r <= ydiff_nxt;
    end
    if (rdy[ST_MIN]) begin
      mx_r <= mx_nxt;
      my_r <= my_nxt;
    end
    if (rdy[ST_SQ]) begin
      sqx_r <= mx_r * mx_r;
      sqy_r <= my_r * my_r;
    end
    if (rdy[ST_OUT]) begin
      out_r.sq_distance <= err_r[ST_SQ] ? '0 : DIST_W'(sqx_r) + DIST_W'(sqy_r);
      out_r.index_error <= err_r[ST_SQ];
    end
  end

  // An empty output stage never stalls the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[ST_OUT] |-> !in_stall)
    else $error("input stalled with empty output stage");

  // Column remainder of an in-range item is below the width
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[DIV_LAST] && !err_r[DIV_LAST]) |->
      ({1'b0, rem_a_r[DIV_LAST]} < REM_W'(w_eff_r)))
    else $error("divider remainder out of range");

  // A result never exceeds 130050, the sum of two squared maximum 8-bit offsets
  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sq_distance <= DIST_W'(130050)))
    else $error("distance above bound");

  // A stalled result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

// ===== dv/torus_min_image_sq_distance_test.sv =====
// ----------------------------------------------------------------------------
// torus_min_image_sq_distance_test: testbench for the torus distance block
// Streams site pairs through several lattice sizes (reset size, largest,
// zero, clamped, single site, one column, one row and random) with bursty
// input and random or periodic output stalls. Each result is checked field
// by field against an in-bench minimum-image distance predictor.
// ----------------------------------------------------------------------------
module torus_min_image_sq_distance_test;
  import tmisd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIST_SAT = 131071;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [SIDE_W-1:0] cfg_data = '0;

  // Shadow copies of the side registers
  logic [SIDE_W-1:0] width_sites_q = SIDE_RESET;
  logic [SIDE_W-1:0] length_sites_q = SIDE_RESET;

  in_item_t pending_pairs[$];
  out_item_t expected_dists[$];

  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_seg = 0;
  stall_mode_t stall_mode = STALL_NONE;

  torus_min_image_sq_distance uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a side register value to the largest supported side
  function automatic int unsigned eff_side(input logic [SIDE_W-1:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  function automatic int sq_sum(input int dx, input int dy);
    return dx * dx + dy * dy;
  endfunction

  // Minimum-image squared distance for one site pair
  function automatic out_item_t torus_distance(input in_item_t pair,
                                               input logic [SIDE_W-1:0] w_reg,
                                               input logic [SIDE_W-1:0] l_reg);
    out_item_t res;
    int w, l, n, a, b;
    int ax, ay, bx, by, hw, hl;
    int sax, say, sbx, sby;
    int best, c;
    bit cross_x, cross_y;
    w = eff_side(w_reg);
    l = eff_side(l_reg);
    n = w * l;
    a = int'(pair.site_a);
    b = int'(pair.site_b);
    res = '0;
    if (a >= n || b >= n) begin
      res.index_error = 1'b1;
      return res;
    end
    ax = a % w;
    ay = a / w;
    bx = b % w;
    by = b / w;
    hw = w / 2;
    hl = l / 2;
    cross_x = (ax >= hw) != (bx >= hw);
    cross_y = (ay >= hl) != (by >= hl);
    // Shift the lower-half coordinate up by the side where halves differ
    sax = ax;
    sbx = bx;
    say = ay;
    sby = by;
    if (cross_x) begin
      if (ax < hw) sax = ax + w;
      else sbx = bx + w;
    end
    if (cross_y) begin
      if (ay < hl) say = ay + l;
      else sby = by + l;
    end
    best = sq_sum(ax - bx, ay - by);
    if (cross_x) begin
      c = sq_sum(sax - sbx, ay - by);
      if (c < best) best = c;
    end
    if (cross_y) begin
      c = sq_sum(sax - sbx, say - sby);
      if (c < best) best = c;
      if (cross_x) begin
        c = sq_sum(ax - bx, say - sby);
        if (c < best) best = c;
      end
    end
    if (best > DIST_SAT) best = DIST_SAT;
    res.sq_distance = DIST_W'(best);
    return res;
  endfunction

  task automatic add_pair(input int unsigned a, input int unsigned b);
    in_item_t p;
    p.site_a = SITE_W'(a);
    p.site_b = SITE_W'(b);
    pending_pairs.push_back(p);
  endtask

  task automatic c_swap(inout int unsigned x, inout int unsigned y);
    int unsigned t;
    t = x;
    x = y;
    y = t;
  endtask

  // Mostly in-range pairs, plus boundary and full-range noise
  task automatic add_random_pairs(input int count);
    int unsigned n, a, b;
    n = eff_side(width_sites_q) * eff_side(length_sites_q);
    for (int k = 0; k < count; k++) begin
      if (n == 0 || $urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
      end else if ($urandom_range(0, 11) == 0) begin
        a = $urandom_range(0, 1) ? n - 1 : n;
        b = $urandom_range(0, n - 1);
        if ($urandom_range(0, 1)) begin
          c_swap(a, b);
        end
      end else begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
      end
      add_pair(a & 16'hFFFF, b & 16'hFFFF);
    end
  endtask

  // Write both side registers back to back; hold valid across the pair
  task automatic set_sides(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] l);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    width_sites_q = w;
    cfg_index <= REG_LENGTH;
    cfg_data <= l;
    do @(posedge clk); while (!cfg_ready);
    length_sites_q = l;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every queued item is sent and every result has come back
  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid || expected_dists.size() != 0)
      @(posedge clk);
  endtask

  // Sender: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_dists.push_back(torus_distance(in_data, width_sites_q, length_sites_q));
    end
    if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_pairs.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_pairs.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each accepted result, stall on a segmented pattern
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_dists.size() == 0) begin
          $error("unexpected result: sq_distance %0d index_error %0b",
                 out_data.sq_distance, out_data.index_error);
          fail_count++;
        end else begin
          want = expected_dists.pop_front();
          if (out_data.sq_distance !== want.sq_distance) begin
            $error("sq_distance mismatch: expected %0d, actual %0d",
                   want.sq_distance, out_data.sq_distance);
            fail_count++;
          end
          if (out_data.index_error !== want.index_error) begin
            $error("index_error mismatch: expected %0b, actual %0b",
                   want.index_error, out_data.index_error);
            fail_count++;
          end
        end
      end
      if (stall_seg == 0) begin
        stall_seg <= $urandom_range(16, 160);
        stall_mode <= stall_mode_t'($urandom_range(0, 2));
      end else begin
        stall_seg <= stall_seg - 1;
      end
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= (stall_seg % 9) < 4;
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [SIDE_W-1:0] rw, rl;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size 16 x 16: corners, wrap, half boundaries, out of range
    add_pair(0, 0);
    add_pair(255, 255);
    add_pair(0, 255);
    add_pair(15, 240);
    add_pair(7, 8);
    add_pair(0, 136);
    add_pair(0, 256);
    add_pair(256, 0);
    add_pair(65535, 65535);
    add_random_pairs(150);
    wait_drained();

    // Largest lattice: every index valid
    set_sides(9'd256, 9'd256);
    add_pair(0, 65535);
    add_pair(65535, 0);
    add_pair(0, 128);
    add_pair(127, 128);
    add_pair(32768, 0);
    add_pair(32767, 32896);
    add_random_pairs(250);
    wait_drained();

    // Zero width: everything out of range
    set_sides(9'd0, 9'd37);
    add_pair(0, 0);
    add_pair(5, 3);
    add_random_pairs(40);
    wait_drained();

    // Sides above the limit are clamped
    set_sides(9'd511, 9'd300);
    add_pair(65535, 0);
    add_pair(0, 65535);
    add_random_pairs(200);
    wait_drained();

    // Single site
    set_sides(9'd1, 9'd1);
    add_pair(0, 0);
    add_pair(0, 1);
    add_pair(1, 0);
    add_random_pairs(40);
    wait_drained();

    // One column
    set_sides(9'd1, 9'd256);
    add_pair(0, 255);
    add_pair(0, 128);
    add_pair(127, 128);
    add_random_pairs(100);
    wait_drained();

    // One row, then zero length
    set_sides(9'd256, 9'd1);
    add_random_pairs(100);
    wait_drained();
    set_sides(9'd5, 9'd0);
    add_random_pairs(20);
    wait_drained();

    // Random sizes, occasionally above the limit
    for (int p = 0; p < 6; p++) begin
      rw = ($urandom_range(0, 4) == 0) ? SIDE_W'($urandom_range(257, 511))
                                       : SIDE_W'($urandom_range(1, 256));
      rl = ($urandom_range(0, 4) == 0) ? SIDE_W'($urandom_range(257, 511))
                                       : SIDE_W'($urandom_range(1, 256));
      set_sides(rw, rl);
      add_random_pairs(80);
      wait_drained();
    end

    // Drain the pipeline and catch any stray results
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
